@@ rtl/trm_pkg.sv @@
// ----------------------------------------------------------------------------
// trm_pkg
// Widths, status codes and reset values shared by the two-ray midpoint
// triangulation core and its sub-units.
// ----------------------------------------------------------------------------
package trm_pkg;

  // digit width of the pipelined multipliers
  localparam int MUL_DIGIT_W = 8;

  // port field widths
  localparam int CW  = 34;             // centre and result coordinates
  localparam int DW  = 32;             // direction components, Q1.30
  localparam int MDW = 40;             // min_denominator register
  localparam int SW  = 2;              // status

  // internal widths
  localparam int WW   = CW + 1;        // c1 - c2 and c1 + c2
  localparam int PW1  = WW + DW;       // dot-product terms
  localparam int ABCW = 2 * DW + 2;    // d1.d1, d1.d2, d2.d2
  localparam int DEW  = PW1 + 3;       // d1.w, d2.w
  localparam int PW2  = DEW + ABCW;    // second-level products
  localparam int NW2  = PW2 + 1;       // determinant and numerators
  localparam int PW3  = NW2 + WW;      // third-level products
  localparam int MW   = PW3 + 2;       // scaled midpoint and gap vectors
  localparam int XW   = MW + 1;        // divider numerators
  localparam int DVW  = NW2 + 1;       // divider divisor, twice the determinant
  localparam int QB   = CW;            // quotient bits
  localparam int VW   = 165;           // gap component once known to be in range
  localparam int SQW  = 2 * VW;        // squared gap component
  localparam int KS   = (SQW + 2) / 2; // square root result bits
  localparam int THR_SHIFT = 60;       // register scale to determinant scale

  localparam logic [MDW-1:0] MIN_DEN_RST = MDW'(11529);

  // result status codes
  typedef enum logic [SW-1:0] {
    ST_OK     = 2'd0,
    ST_DEGEN  = 2'd1,
    ST_BEHIND = 2'd2,
    ST_OVF    = 2'd3
  } status_t;

endpackage

@@ rtl/trm_in_if.sv @@
// ----------------------------------------------------------------------------
// trm_in_if
// Ray-pair request channel: two origins and two directions.
// ----------------------------------------------------------------------------
interface trm_in_if;
  logic valid;
  logic ready;
  logic signed [trm_pkg::CW-1:0] first_center_x;
  logic signed [trm_pkg::CW-1:0] first_center_y;
  logic signed [trm_pkg::CW-1:0] first_center_z;
  logic signed [trm_pkg::DW-1:0] first_dir_x;
  logic signed [trm_pkg::DW-1:0] first_dir_y;
  logic signed [trm_pkg::DW-1:0] first_dir_z;
  logic signed [trm_pkg::CW-1:0] second_center_x;
  logic signed [trm_pkg::CW-1:0] second_center_y;
  logic signed [trm_pkg::CW-1:0] second_center_z;
  logic signed [trm_pkg::DW-1:0] second_dir_x;
  logic signed [trm_pkg::DW-1:0] second_dir_y;
  logic signed [trm_pkg::DW-1:0] second_dir_z;

  modport source (
    output valid, first_center_x, first_center_y, first_center_z,
    output first_dir_x, first_dir_y, first_dir_z,
    output second_center_x, second_center_y, second_center_z,
    output second_dir_x, second_dir_y, second_dir_z,
    input  ready
  );
  modport sink (
    input  valid, first_center_x, first_center_y, first_center_z,
    input  first_dir_x, first_dir_y, first_dir_z,
    input  second_center_x, second_center_y, second_center_z,
    input  second_dir_x, second_dir_y, second_dir_z,
    output ready
  );
endinterface

@@ rtl/trm_out_if.sv @@
// ----------------------------------------------------------------------------
// trm_out_if
// Result channel: midpoint, separation and status.
// ----------------------------------------------------------------------------
interface trm_out_if;
  logic valid;
  logic ready;
  logic signed [trm_pkg::CW-1:0] point_x;
  logic signed [trm_pkg::CW-1:0] point_y;
  logic signed [trm_pkg::CW-1:0] point_z;
  logic        [trm_pkg::CW-1:0] separation;
  logic        [trm_pkg::SW-1:0] status;

  modport source (output valid, point_x, point_y, point_z, separation, status,
                  input ready);
  modport sink (input valid, point_x, point_y, point_z, separation, status,
                output ready);
endinterface

@@ rtl/trm_cfg_if.sv @@
// ----------------------------------------------------------------------------
// trm_cfg_if
// Configuration write channel for the min_denominator register.
// ----------------------------------------------------------------------------
interface trm_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [trm_pkg::MDW-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ rtl/two_ray_midpoint_triangulation_core.sv @@
// ----------------------------------------------------------------------------
// two_ray_midpoint_triangulation_core
// Midpoint and separation of the closest points of two rays, exact fixed point.
// Pipeline: the 166-stage root unit, the four 34-stage dividers and the
//   digit-serial multiplier chain, at an 8-bit multiplier digit.
// Throughput: one ray pair per cycle while the result side takes results.
// Reset: clears the pipeline valid bits and loads min_denominator with 11529.
// ----------------------------------------------------------------------------
module two_ray_midpoint_triangulation_core #(
  parameter int DIGIT_W = trm_pkg::MUL_DIGIT_W
) (
  input  logic      clk,
  input  logic      rst,
  trm_in_if.sink    rays,
  trm_out_if.source result,
  trm_cfg_if.sink   cfg
);

  localparam int CW   = trm_pkg::CW;
  localparam int DW   = trm_pkg::DW;
  localparam int WW   = trm_pkg::WW;
  localparam int PW1  = trm_pkg::PW1;
  localparam int ABCW = trm_pkg::ABCW;
  localparam int DEW  = trm_pkg::DEW;
  localparam int PW2  = trm_pkg::PW2;
  localparam int NW2  = trm_pkg::NW2;
  localparam int PW3  = trm_pkg::PW3;
  localparam int MW   = trm_pkg::MW;
  localparam int XW   = trm_pkg::XW;
  localparam int DVW  = trm_pkg::DVW;
  localparam int QB   = trm_pkg::QB;
  localparam int VW   = trm_pkg::VW;
  localparam int SQW  = trm_pkg::SQW;
  localparam int KS   = trm_pkg::KS;
  localparam int SIDE = 2 * WW + 2 * DW;

  // multiplier depths
  localparam int L1 = (DW + DIGIT_W - 1) / DIGIT_W;
  localparam int L2 = (ABCW + DIGIT_W - 1) / DIGIT_W;
  localparam int L3 = (WW + DIGIT_W - 1) / DIGIT_W;
  localparam int L4 = (VW + DIGIT_W - 1) / DIGIT_W;

  // register slots along the pipe
  localparam int T_IN  = 1;
  localparam int T_DOT = T_IN + L1 + 1;
  localparam int T_NUM = T_DOT + L2 + 1;
  localparam int T_FLG = T_NUM + 1;
  localparam int T_MV  = T_NUM + L3 + 1;
  localparam int T_XP  = T_MV + 1;
  localparam int T_CHK = T_XP + 1;
  localparam int T_SUM = T_CHK + L4 + 1;
  localparam int T_SQ  = T_SUM + KS;
  localparam int T_XS  = T_SQ + 1;
  localparam int T_PRE = T_XS + QB;
  localparam int T_OUT = T_PRE + 1;

  // pipeline advance and valid bits
  logic             adv;
  logic [T_OUT-1:0] vld;

  assign adv        = ~vld[T_OUT-1] | result.ready;
  assign rays.ready = adv;
  assign result.valid = vld[T_OUT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[T_OUT-2:0], rays.valid};
    end
  end

  // configuration register
  logic [trm_pkg::MDW-1:0] md;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      md <= trm_pkg::MIN_DEN_RST;
    end else if (cfg.valid) begin
      md <= cfg.data;
    end
  end

  // request fields as arrays
  logic signed [CW-1:0] c1 [3];
  logic signed [CW-1:0] c2 [3];
  logic signed [DW-1:0] d1 [3];
  logic signed [DW-1:0] d2 [3];

  assign c1[0] = rays.first_center_x;
  assign c1[1] = rays.first_center_y;
  assign c1[2] = rays.first_center_z;
  assign c2[0] = rays.second_center_x;
  assign c2[1] = rays.second_center_y;
  assign c2[2] = rays.second_center_z;
  assign d1[0] = rays.first_dir_x;
  assign d1[1] = rays.first_dir_y;
  assign d1[2] = rays.first_dir_z;
  assign d2[0] = rays.second_dir_x;
  assign d2[1] = rays.second_dir_y;
  assign d2[2] = rays.second_dir_z;

  // input stage: origin difference and sum
  logic signed [WW-1:0] w_q  [3];
  logic signed [WW-1:0] sm_q [3];
  logic signed [DW-1:0] d1_q [3];
  logic signed [DW-1:0] d2_q [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        w_q[k]  <= WW'(c1[k]) - WW'(c2[k]);
        sm_q[k] <= WW'(c1[k]) + WW'(c2[k]);
        d1_q[k] <= d1[k];
        d2_q[k] <= d2[k];
      end
    end
  end

  // dot-product terms
  logic signed [PW1-1:0] pa [3];
  logic signed [PW1-1:0] pb [3];
  logic signed [PW1-1:0] pc [3];
  logic signed [PW1-1:0] pd [3];
  logic signed [PW1-1:0] pe [3];
  logic signed [WW-1:0]  sm_d [3];
  logic signed [WW-1:0]  w_d  [3];
  logic signed [DW-1:0]  d1_d [3];
  logic signed [DW-1:0]  d2_d [3];

  for (genvar k = 0; k < 3; k++) begin : g_dot
    logic [SIDE-1:0] side_d;

    trm_mul #(.WA(WW), .WB(DW), .DIGIT_W(DIGIT_W)) u_aa (
      .clk(clk), .en(adv), .a(WW'(d1_q[k])), .b(d1_q[k]), .p(pa[k]));
    trm_mul #(.WA(WW), .WB(DW), .DIGIT_W(DIGIT_W)) u_bb (
      .clk(clk), .en(adv), .a(WW'(d2_q[k])), .b(d1_q[k]), .p(pb[k]));
    trm_mul #(.WA(WW), .WB(DW), .DIGIT_W(DIGIT_W)) u_cc (
      .clk(clk), .en(adv), .a(WW'(d2_q[k])), .b(d2_q[k]), .p(pc[k]));
    trm_mul #(.WA(WW), .WB(DW), .DIGIT_W(DIGIT_W)) u_dd (
      .clk(clk), .en(adv), .a(w_q[k]), .b(d1_q[k]), .p(pd[k]));
    trm_mul #(.WA(WW), .WB(DW), .DIGIT_W(DIGIT_W)) u_ee (
      .clk(clk), .en(adv), .a(w_q[k]), .b(d2_q[k]), .p(pe[k]));

    // origin terms and directions wait for the numerators
    trm_dly #(.W(SIDE), .N(T_NUM - T_IN)) u_side (
      .clk(clk), .en(adv), .d({sm_q[k], w_q[k], d1_q[k], d2_q[k]}), .q(side_d));

    assign sm_d[k] = side_d[SIDE-1 -: WW];
    assign w_d[k]  = side_d[SIDE-WW-1 -: WW];
    assign d1_d[k] = side_d[2*DW-1 -: DW];
    assign d2_d[k] = side_d[DW-1:0];
  end

  // dot-product sums
  logic signed [ABCW-1:0] a_q, b_q, c_q;
  logic signed [DEW-1:0]  d_q, e_q;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_q <= ABCW'(pa[0]) + ABCW'(pa[1]) + ABCW'(pa[2]);
      b_q <= ABCW'(pb[0]) + ABCW'(pb[1]) + ABCW'(pb[2]);
      c_q <= ABCW'(pc[0]) + ABCW'(pc[1]) + ABCW'(pc[2]);
      d_q <= DEW'(pd[0]) + DEW'(pd[1]) + DEW'(pd[2]);
      e_q <= DEW'(pe[0]) + DEW'(pe[1]) + DEW'(pe[2]);
    end
  end

  // zero direction flags follow to the determinant
  logic [1:0] zr_d;

  trm_dly #(.W(2), .N(T_NUM - T_DOT)) u_zr (
    .clk(clk), .en(adv), .d({a_q == '0, c_q == '0}), .q(zr_d));

  // second-level products
  logic signed [PW2-1:0] p_ac, p_bb, p_be, p_cd, p_ae, p_bd;

  trm_mul #(.WA(DEW), .WB(ABCW), .DIGIT_W(DIGIT_W)) u_ac (
    .clk(clk), .en(adv), .a(DEW'(a_q)), .b(c_q), .p(p_ac));
  trm_mul #(.WA(DEW), .WB(ABCW), .DIGIT_W(DIGIT_W)) u_bb2 (
    .clk(clk), .en(adv), .a(DEW'(b_q)), .b(b_q), .p(p_bb));
  trm_mul #(.WA(DEW), .WB(ABCW), .DIGIT_W(DIGIT_W)) u_be (
    .clk(clk), .en(adv), .a(e_q), .b(b_q), .p(p_be));
  trm_mul #(.WA(DEW), .WB(ABCW), .DIGIT_W(DIGIT_W)) u_cd (
    .clk(clk), .en(adv), .a(d_q), .b(c_q), .p(p_cd));
  trm_mul #(.WA(DEW), .WB(ABCW), .DIGIT_W(DIGIT_W)) u_ae (
    .clk(clk), .en(adv), .a(e_q), .b(a_q), .p(p_ae));
  trm_mul #(.WA(DEW), .WB(ABCW), .DIGIT_W(DIGIT_W)) u_bd (
    .clk(clk), .en(adv), .a(d_q), .b(b_q), .p(p_bd));

  // determinant and numerators
  logic signed [NW2-1:0] den_q, n1_q, n2_q;

  always_ff @(posedge clk) begin
    if (adv) begin
      den_q <= NW2'(p_ac) - NW2'(p_bb);
      n1_q  <= NW2'(p_be) - NW2'(p_cd);
      n2_q  <= NW2'(p_ae) - NW2'(p_bd);
    end
  end

  // rejection flags and the offset determinant
  logic signed [NW2-1:0] thr;
  logic                  degen_q, behind_q;
  logic signed [MW-1:0]  denk_q;

  assign thr = $signed(NW2'({md, trm_pkg::THR_SHIFT'(0)}));

  always_ff @(posedge clk) begin
    if (adv) begin
      degen_q  <= zr_d[1] | zr_d[0] | (den_q <= 0) | (den_q < thr);
      behind_q <= (n1_q <= 0) | (n2_q <= 0);
      denk_q   <= (MW'(den_q) <<< CW) + MW'(den_q);
    end
  end

  // third-level products, midpoint and gap vectors
  logic signed [MW-1:0]  m_q [3];
  logic signed [MW-1:0]  v_q [3];
  logic signed [MW-1:0]  denk_d;
  logic signed [XW-1:0]  xp_q [3];
  logic        [MW-1:0]  av_q [3];
  logic        [NW2-1:0] den_xp;

  trm_dly #(.W(MW), .N(T_MV - T_FLG)) u_denk (
    .clk(clk), .en(adv), .d(denk_q), .q(denk_d));
  trm_dly #(.W(NW2), .N(T_XP - T_NUM)) u_den_xp (
    .clk(clk), .en(adv), .d(den_q), .q(den_xp));

  for (genvar k = 0; k < 3; k++) begin : g_vec
    logic signed [PW3-1:0] p_ds, p_dw, p_1, p_2;

    trm_mul #(.WA(NW2), .WB(WW), .DIGIT_W(DIGIT_W)) u_ds (
      .clk(clk), .en(adv), .a(den_q), .b(sm_d[k]), .p(p_ds));
    trm_mul #(.WA(NW2), .WB(WW), .DIGIT_W(DIGIT_W)) u_dw (
      .clk(clk), .en(adv), .a(den_q), .b(w_d[k]), .p(p_dw));
    trm_mul #(.WA(NW2), .WB(WW), .DIGIT_W(DIGIT_W)) u_n1 (
      .clk(clk), .en(adv), .a(n1_q), .b(WW'(d1_d[k])), .p(p_1));
    trm_mul #(.WA(NW2), .WB(WW), .DIGIT_W(DIGIT_W)) u_n2 (
      .clk(clk), .en(adv), .a(n2_q), .b(WW'(d2_d[k])), .p(p_2));

    // m is twice the midpoint, v the gap, both scaled by the determinant
    always_ff @(posedge clk) begin
      if (adv) begin
        m_q[k]  <= MW'(p_ds) + MW'(p_1) + MW'(p_2);
        v_q[k]  <= MW'(p_dw) + MW'(p_1) - MW'(p_2);
        xp_q[k] <= XW'(m_q[k]) + XW'(denk_d);
        av_q[k] <= v_q[k][MW-1] ? MW'(-v_q[k]) : MW'(v_q[k]);
      end
    end
  end

  // range checks, clipped gap and point division
  logic [2:0]          lo_q, hi_q, big_q;
  logic signed [VW-1:0] vc_q [3];
  logic [QB-1:0]       qp [3];
  logic [QB-1:0]       qp_d [3];

  for (genvar k = 0; k < 3; k++) begin : g_pt
    always_ff @(posedge clk) begin
      if (adv) begin
        lo_q[k]  <= xp_q[k][XW-1];
        hi_q[k]  <= ~xp_q[k][XW-1] &
                    ($unsigned(xp_q[k]) >= (XW'(den_xp) << (CW + 1)));
        big_q[k] <= av_q[k] >= (MW'(den_xp) << CW);
        vc_q[k]  <= $signed({1'b0, av_q[k][VW-2:0]});
      end
    end

    // floor((m + den) / (2 den)) offset by half the output range
    trm_div #(.WN(XW), .WD(DVW), .QB(QB)) u_div (
      .clk(clk), .en(adv), .n($unsigned(xp_q[k])), .dv({den_xp, 1'b0}), .q(qp[k]));

    trm_dly #(.W(QB), .N(T_PRE - T_XP - QB)) u_qd (
      .clk(clk), .en(adv), .d(qp[k]), .q(qp_d[k]));
  end

  // squared gap length
  logic signed [SQW-1:0] sq [3];
  logic [2*KS-1:0]       s4_q;

  for (genvar k = 0; k < 3; k++) begin : g_sq
    trm_mul #(.WA(VW), .WB(VW), .DIGIT_W(DIGIT_W)) u_sq (
      .clk(clk), .en(adv), .a(vc_q[k]), .b(vc_q[k]), .p(sq[k]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_q <= ((2*KS)'($unsigned(sq[0])) + (2*KS)'($unsigned(sq[1])) +
               (2*KS)'($unsigned(sq[2]))) << 2;
    end
  end

  // root of four times the squared gap
  logic [KS-1:0]  rt;
  logic [NW2-1:0] den_sq, den_xs;
  logic [XW-1:0]  xs_q;
  logic           shi_q, shi_d;
  logic [QB-1:0]  qs;

  trm_sqrt #(.K(KS)) u_sqrt (.clk(clk), .en(adv), .rad(s4_q), .root(rt));

  trm_dly #(.W(NW2), .N(T_SQ - T_NUM)) u_den_sq (
    .clk(clk), .en(adv), .d(den_q), .q(den_sq));
  trm_dly #(.W(NW2), .N(1)) u_den_xs (
    .clk(clk), .en(adv), .d(den_sq), .q(den_xs));

  // separation numerator, rounding half up
  always_ff @(posedge clk) begin
    if (adv) begin
      xs_q  <= XW'(rt) + XW'(den_sq);
      shi_q <= xs_q >= (XW'(den_xs) << (CW + 1));
    end
  end

  trm_div #(.WN(XW), .WD(DVW), .QB(QB)) u_sdiv (
    .clk(clk), .en(adv), .n(xs_q), .dv({den_xs, 1'b0}), .q(qs));

  trm_dly #(.W(1), .N(T_PRE - T_XS - 1)) u_shi (
    .clk(clk), .en(adv), .d(shi_q), .q(shi_d));

  // flags brought to the output stage
  logic [6:0] rng_d;
  logic [1:0] rej_d;

  trm_dly #(.W(7), .N(T_PRE - T_CHK)) u_rng (
    .clk(clk), .en(adv), .d({lo_q, hi_q, |big_q}), .q(rng_d));
  trm_dly #(.W(2), .N(T_PRE - T_FLG)) u_rej (
    .clk(clk), .en(adv), .d({degen_q, behind_q}), .q(rej_d));

  // output stage: rejection, saturation and status
  logic signed [CW-1:0] pt_next [3];
  logic [CW-1:0]        sep_next;
  logic [CW-1:0]        sep_q;
  logic signed [CW-1:0] pt_q [3];
  trm_pkg::status_t     st_next, st_q;

  always_comb begin
    logic ovf;
    ovf = shi_d | rng_d[0] | (|rng_d[6:4]) | (|rng_d[3:1]);
    for (int k = 0; k < 3; k++) begin
      if (rng_d[4 + k]) begin
        pt_next[k] = {1'b1, {(CW-1){1'b0}}};
      end else if (rng_d[1 + k]) begin
        pt_next[k] = {1'b0, {(CW-1){1'b1}}};
      end else begin
        pt_next[k] = {~qp_d[k][QB-1], qp_d[k][QB-2:0]};
      end
    end
    sep_next = (shi_d | rng_d[0]) ? {CW{1'b1}} : qs;
    st_next  = ovf ? trm_pkg::ST_OVF : trm_pkg::ST_OK;
    priority if (rej_d[1]) begin
      st_next = trm_pkg::ST_DEGEN;
    end else if (rej_d[0]) begin
      st_next = trm_pkg::ST_BEHIND;
    end
    if (rej_d[1] | rej_d[0]) begin
      for (int k = 0; k < 3; k++) begin
        pt_next[k] = '0;
      end
      sep_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        pt_q[k] <= pt_next[k];
      end
      sep_q <= sep_next;
      st_q  <= st_next;
    end
  end

  assign result.point_x    = pt_q[0];
  assign result.point_y    = pt_q[1];
  assign result.point_z    = pt_q[2];
  assign result.separation = sep_q;
  assign result.status     = st_q;

  // a stalled result holds the whole pipe
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |-> !rays.ready)
    else $error("request taken while result stalled");

  // an accepted request enters the pipe
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (rays.valid && rays.ready) |=> vld[0])
    else $error("accepted request lost at pipe entry");

  // rejected pairs carry zero geometry
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.status == trm_pkg::ST_DEGEN ||
                      result.status == trm_pkg::ST_BEHIND)) |->
    (result.point_x == '0 && result.point_y == '0 && result.point_z == '0 &&
     result.separation == '0))
    else $error("rejected pair with non-zero result");

endmodule

@@ rtl/trm_dly.sv @@
// ----------------------------------------------------------------------------
// trm_dly
// Enabled delay line that keeps side data in step with the pipeline.
// ----------------------------------------------------------------------------
module trm_dly #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  if (N == 0) begin : g_none
    assign q = d;
  end else begin : g_line
    logic [W-1:0] sr [N];

    // shift one place per pipeline advance
    always_ff @(posedge clk) begin
      if (en) begin
        sr[0] <= d;
        for (int i = 1; i < N; i++) begin
          sr[i] <= sr[i-1];
        end
      end
    end

    assign q = sr[N-1];
  end

endmodule

@@ rtl/trm_mul.sv @@
// ----------------------------------------------------------------------------
// trm_mul
// Pipelined signed multiplier, one digit of operand b per stage.
// ----------------------------------------------------------------------------
module trm_mul #(
  parameter int WA      = 32,
  parameter int WB      = 32,
  parameter int DIGIT_W = trm_pkg::MUL_DIGIT_W
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  localparam int WP  = WA + WB;
  localparam int NS  = (WB + DIGIT_W - 1) / DIGIT_W;
  localparam int WBX = NS * DIGIT_W;

  logic signed [WA-1:0]  a_q   [NS];
  logic signed [WBX-1:0] b_q   [NS];
  logic signed [WP-1:0]  acc_q [NS];
  logic signed [WBX-1:0] b_ext;

  assign b_ext = WBX'(b);

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic signed [WA-1:0]      a_in;
    logic signed [WBX-1:0]     b_in;
    logic signed [WP-1:0]      acc_in;
    logic signed [DIGIT_W:0]   dig;
    logic signed [WA+DIGIT_W:0] pp;

    if (s == 0) begin : g_first
      assign a_in   = a;
      assign b_in   = b_ext;
      assign acc_in = '0;
    end else begin : g_next
      assign a_in   = a_q[s-1];
      assign b_in   = b_q[s-1];
      assign acc_in = acc_q[s-1];
    end

    // lower digits unsigned, top digit carries the sign
    assign dig = {(s == NS - 1) ? b_in[WBX-1] : 1'b0, b_in[s*DIGIT_W +: DIGIT_W]};
    assign pp  = a_in * dig;

    // accumulate the weighted partial product
    always_ff @(posedge clk) begin
      if (en) begin
        a_q[s]   <= a_in;
        b_q[s]   <= b_in;
        acc_q[s] <= acc_in + (WP'(pp) <<< (s * DIGIT_W));
      end
    end
  end

  assign p = acc_q[NS-1];

endmodule

@@ rtl/trm_div.sv @@
// ----------------------------------------------------------------------------
// trm_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module trm_div #(
  parameter int WN = trm_pkg::XW,
  parameter int WD = trm_pkg::DVW,
  parameter int QB = trm_pkg::QB
) (
  input  logic          clk,
  input  logic          en,
  input  logic [WN-1:0] n,
  input  logic [WD-1:0] dv,
  output logic [QB-1:0] q
);

  logic [WN-1:0] rem_q [QB];
  logic [WD-1:0] dv_q  [QB];
  logic [QB-1:0] q_q   [QB];

  for (genvar j = 0; j < QB; j++) begin : g_stage
    logic [WN-1:0] rem_in;
    logic [WD-1:0] dv_in;
    logic [QB-1:0] q_in;
    logic [WN-1:0] sh;
    logic [WN:0]   diff;
    logic          ge;

    if (j == 0) begin : g_first
      assign rem_in = n;
      assign dv_in  = dv;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign dv_in  = dv_q[j-1];
      assign q_in   = q_q[j-1];
    end

    // trial subtract of the aligned divisor
    assign sh   = WN'(dv_in) << (QB - 1 - j);
    assign diff = {1'b0, rem_in} - {1'b0, sh};
    assign ge   = ~diff[WN];

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j] <= ge ? diff[WN-1:0] : rem_in;
        dv_q[j]  <= dv_in;
        q_q[j]   <= ge ? (q_in | (QB'(1) << (QB - 1 - j))) : q_in;
      end
    end
  end

  assign q = q_q[QB-1];

endmodule

@@ rtl/trm_sqrt.sv @@
// ----------------------------------------------------------------------------
// trm_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module trm_sqrt #(
  parameter int K = trm_pkg::KS
) (
  input  logic           clk,
  input  logic           en,
  input  logic [2*K-1:0] rad,
  output logic [K-1:0]   root
);

  logic [K+1:0]   rem_q  [K];
  logic [K-1:0]   root_q [K];
  logic [2*K-1:0] rad_q  [K];

  for (genvar i = 0; i < K; i++) begin : g_stage
    logic [K+1:0]   rem_in;
    logic [K-1:0]   root_in;
    logic [2*K-1:0] rad_in;
    logic [K+1:0]   rem_sh;
    logic [K+1:0]   trial;
    logic [K+2:0]   diff;
    logic           ge;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign rad_in  = rad_q[i-1];
    end

    // bring down two radicand bits and try 4r+1
    assign rem_sh = {rem_in[K-1:0], rad_in[2*K-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign diff   = {1'b0, rem_sh} - {1'b0, trial};
    assign ge     = ~diff[K+2];

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i]  <= ge ? diff[K+1:0] : rem_sh;
        root_q[i] <= {root_in[K-2:0], ge};
        rad_q[i]  <= rad_in << 2;
      end
    end
  end

  assign root = root_q[K-1];

endmodule
